### rtl/jsu_pkg.sv
// Shared types, codes and helper functions for the JSON string unescaper.
// No dependencies; every module of the block imports this package.
package jsu_pkg;

    // Result kinds on the output channel.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Characters that steer the decoder.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    // Top six bits of a high and a low surrogate.
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

    // What the back end does with the data part of a bundle.
    typedef enum logic [1:0] {
        DATA_NONE = 2'd0,
        DATA_RAW  = 2'd1,
        DATA_UTF8 = 2'd2
    } data_op_t;

    // One accepted input byte, classified: optional data and optional status.
    typedef struct packed {
        data_op_t    op;
        logic [20:0] value;
        logic        has_status;
        logic [1:0]  status_kind;
    } bundle_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    // Decodes one ASCII hex digit; valid is low for anything else.
    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.value = 4'(b - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    // Number of UTF-8 bytes that encode a code point.
    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp < 21'h80) begin
            n = 3'd1;
        end else if (cp < 21'h800) begin
            n = 3'd2;
        end else if (cp < 21'h10000) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    // Byte idx of the UTF-8 encoding of cp, whose length is len.
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                             input logic [1:0]  idx,
                                             input logic [2:0]  len);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            3'd1: b = cp[7:0];
            3'd2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3:
            begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

### rtl/jsu_in_if.sv
// Input channel of the JSON string unescaper: one raw text byte per word.
// Depends on nothing.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, in_byte, end_of_text, input ready);
    modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

### rtl/jsu_out_if.sv
// Output channel of the JSON string unescaper: one decoded byte or status per word.
// Depends on nothing.
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, out_byte, kind, last, input ready);
    modport sink   (input valid, out_byte, kind, last, output ready);
endinterface

### rtl/json_string_unescape_utf8.sv
// Channel   Dir   Word contents                 Accepted when
// in_ch     in    in_byte, end_of_text          valid && ready
// out_ch    out   out_byte, kind, last          valid && ready
//
// Input is taken at one byte per cycle while the bundle queue has room.
// Each byte yields zero to five output words, sent at one word per cycle while
// the output is ready, so a \u escape that encodes to four UTF-8 bytes holds the
// output for four words; the QUEUE_DEPTH-entry queue absorbs such bursts. An
// accepted byte's first output word passes through the queue and then the output
// register. An output stall backs up the queue and then stalls the input. Reset
// is asynchronous, active low, and leaves the decoder waiting for an opening quote with the queue empty.
//
// Top level of the JSON string unescaper: front end, bundle queue, back end.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_queue, jsu_back.
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    in_ch,
    jsu_out_if.source out_ch
);

    logic    push;
    bundle_t push_data;
    logic    pop;
    logic    queue_full;
    logic    head_valid;
    bundle_t head;

    // Byte classification and escape decoding.
    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // Decouples the front end from output stalls.
    jsu_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (head_valid),
        .head      (head)
    );

    // UTF-8 expansion and output register.
    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

### rtl/jsu_front.sv
// Front end: accepts text bytes, runs the escape state machine and classifies
// each byte into a bundle for the queue. Depends on jsu_pkg and jsu_in_if.
module jsu_front
    import jsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    jsu_in_if.sink   in_ch,
    input  logic     queue_full,
    output logic     push,
    output bundle_t  push_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_STR   = 7'b0000010,
        S_ESC   = 7'b0000100,
        S_HEX   = 7'b0001000,
        S_HI_BS = 7'b0010000,
        S_HI_U  = 7'b0100000,
        S_LO    = 7'b1000000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [15:0]  accum_reg, accum_next;
    logic [9:0]   high_reg, high_next;
    logic [1:0]   digit_reg, digit_next;

    logic        accept;
    logic [7:0]  b;
    hex_t        hx;
    logic [15:0] acc_shift;
    bundle_t     bnd;

    assign in_ch.ready = !queue_full;
    assign accept      = in_ch.valid && !queue_full;
    assign b           = in_ch.in_byte;
    assign hx          = hex_digit(b);
    assign acc_shift   = {accum_reg[11:0], hx.value};

    // Classify the byte against the current state.
    always_comb
    begin
        state_next      = state_reg;
        accum_next      = accum_reg;
        high_next       = high_reg;
        digit_next      = digit_reg;
        bnd.op          = DATA_NONE;
        bnd.value       = 21'd0;
        bnd.has_status  = 1'b0;
        bnd.status_kind = KIND_DATA;

        case (state_reg)
            S_STR:
            begin
                if (b == CH_QUOTE) begin
                    bnd.has_status  = 1'b1;
                    bnd.status_kind = KIND_CLOSE;
                end else if (b == CH_BSLASH) begin
                    state_next = S_ESC;
                end else if (b < CTRL_LIMIT) begin
                    bnd.has_status  = 1'b1;
                    bnd.status_kind = KIND_ERROR;
                end else begin
                    bnd.op    = DATA_RAW;
                    bnd.value = {13'd0, b};
                end
            end
            S_ESC:
            begin
                state_next = S_STR;
                bnd.op     = DATA_RAW;
                case (b)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: bnd.value = {13'd0, b};
                    CH_B: bnd.value = 21'h08;
                    CH_F: bnd.value = 21'h0C;
                    CH_N: bnd.value = 21'h0A;
                    CH_R: bnd.value = 21'h0D;
                    CH_T: bnd.value = 21'h09;
                    CH_U:
                    begin
                        bnd.op     = DATA_NONE;
                        accum_next = 16'd0;
                        digit_next = 2'd0;
                        state_next = S_HEX;
                    end
                    default:
                    begin
                        bnd.op          = DATA_NONE;
                        bnd.has_status  = 1'b1;
                        bnd.status_kind = KIND_ERROR;
                    end
                endcase
            end
            S_HEX:
            begin
                if (!hx.valid) begin
                    bnd.has_status  = 1'b1;
                    bnd.status_kind = KIND_ERROR;
                end else begin
                    accum_next = acc_shift;
                    if (digit_reg != 2'd3) begin
                        digit_next = digit_reg + 2'd1;
                    end else if (acc_shift[15:10] == SURR_HIGH_TAG) begin
                        high_next  = acc_shift[9:0];
                        state_next = S_HI_BS;
                    end else if (acc_shift[15:10] == SURR_LOW_TAG) begin
                        bnd.has_status  = 1'b1;
                        bnd.status_kind = KIND_ERROR;
                    end else begin
                        bnd.op     = DATA_UTF8;
                        bnd.value  = {5'd0, acc_shift};
                        state_next = S_STR;
                    end
                end
            end
            S_HI_BS:
            begin
                if (b == CH_BSLASH) begin
                    state_next = S_HI_U;
                end else begin
                    bnd.has_status  = 1'b1;
                    bnd.status_kind = KIND_ERROR;
                end
            end
            S_HI_U:
            begin
                if (b == CH_U) begin
                    accum_next = 16'd0;
                    digit_next = 2'd0;
                    state_next = S_LO;
                end else begin
                    bnd.has_status  = 1'b1;
                    bnd.status_kind = KIND_ERROR;
                end
            end
            S_LO:
            begin
                if (!hx.valid) begin
                    bnd.has_status  = 1'b1;
                    bnd.status_kind = KIND_ERROR;
                end else begin
                    accum_next = acc_shift;
                    if (digit_reg != 2'd3) begin
                        digit_next = digit_reg + 2'd1;
                    end else if (acc_shift[15:10] == SURR_LOW_TAG) begin
                        bnd.op     = DATA_UTF8;
                        bnd.value  = SUPPLEMENTARY_BASE
                                   + {1'b0, high_reg, acc_shift[9:0]};
                        state_next = S_STR;
                    end else begin
                        bnd.has_status  = 1'b1;
                        bnd.status_kind = KIND_ERROR;
                    end
                end
            end
            default:
            begin
                // Idle: only an opening quote starts a string.
                if (b == CH_QUOTE) begin
                    state_next = S_STR;
                end else begin
                    bnd.has_status  = 1'b1;
                    bnd.status_kind = KIND_ERROR;
                end
            end
        endcase

        // Text that ends without a status is an unterminated string.
        if (!bnd.has_status && in_ch.end_of_text) begin
            bnd.has_status  = 1'b1;
            bnd.status_kind = KIND_ERROR;
        end

        // Any status returns the decoder to its reset state.
        if (bnd.has_status) begin
            state_next = S_IDLE;
            accum_next = 16'd0;
            high_next  = 10'd0;
            digit_next = 2'd0;
        end
    end

    assign push      = accept && (bnd.op != DATA_NONE || bnd.has_status);
    assign push_data = bnd;

    // Decoder state advances on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            accum_reg <= 16'd0;
            high_reg  <= 10'd0;
            digit_reg <= 2'd0;
        end else if (accept) begin
            state_reg <= state_next;
            accum_reg <= accum_next;
            high_reg  <= high_next;
            digit_reg <= digit_next;
        end
    end

endmodule

### rtl/jsu_queue.sv
// Small register FIFO of classified bundles between front and back end.
// Depends on jsu_pkg.
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output logic    full,
    output logic    not_empty,
    output bundle_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bundle_t            store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Bundle storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/jsu_back.sv
// Back end: expands the bundle at the queue head into its data byte or UTF-8
// bytes and its status word, if any, one per cycle while the output is not
// stalled, through an output register. Depends on jsu_pkg and jsu_out_if.
module jsu_back
    import jsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    input  bundle_t  head,
    output logic     pop,
    jsu_out_if.source out_ch
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [1:0] kind_reg, kind_next;
    logic       last_reg, last_next;
    logic [2:0] idx_reg, idx_next;

    logic [2:0] data_len;
    logic [2:0] total;
    logic       load;

    // Word count of the head bundle.
    always_comb
    begin
        case (head.op)
            DATA_RAW:  data_len = 3'd1;
            DATA_UTF8: data_len = utf8_len(head.value);
            default:   data_len = 3'd0;
        endcase
        total = data_len + {2'd0, head.has_status};
    end

    assign load = head_valid && (!out_valid_reg || out_ch.ready);
    assign pop  = load && ((idx_reg + 3'd1) == total);

    // Next output word and bundle position.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_byte_next  = out_byte_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        if (load) begin
            out_valid_next = 1'b1;
            idx_next       = pop ? 3'd0 : idx_reg + 3'd1;
            if (idx_reg < data_len) begin
                out_byte_next = (head.op == DATA_RAW) ? head.value[7:0]
                              : utf8_byte(head.value, idx_reg[1:0], data_len);
                kind_next     = KIND_DATA;
                last_next     = 1'b0;
            end else begin
                out_byte_next = 8'h00;
                kind_next     = head.status_kind;
                last_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        kind_reg     <= kind_next;
        last_reg     <= last_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.kind     = kind_reg;
    assign out_ch.last     = last_reg;

endmodule

### sim/jsu_decode_check.sv
`timescale 1ns / 100ps
// Checker for the JSON string unescaper: watches both channels, decodes each accepted
// input word on its own and compares every output word with the oldest expected one.
// Depends on jsu_pkg, jsu_in_if and jsu_out_if.
module jsu_decode_check
    import jsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    jsu_in_if    in_ch,
    jsu_out_if   out_ch,
    output int   fail_count,
    output int   pending_results
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TEXT,
        ST_ESC,
        ST_HEX1,
        ST_HEX2,
        ST_HEX3,
        ST_HEX4,
        ST_PAIR_BS,
        ST_PAIR_U,
        ST_LO1,
        ST_LO2,
        ST_LO3,
        ST_LO4
    } decode_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } text_result_t;

    decode_state_t  mode;
    logic [15:0]    hex_acc;
    logic [9:0]     hi_half;
    text_result_t   expected_q[$];

    // Value of an ASCII hex digit, or -1 when the byte is not one.
    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= "0" && b <= "9")
        begin
            return int'(b - "0");
        end
        if (b >= "a" && b <= "f")
        begin
            return int'(b - "a") + 10;
        end
        if (b >= "A" && b <= "F")
        begin
            return int'(b - "A") + 10;
        end
        return -1;
    endfunction

    // Adds one expected word at the tail of the queue.
    function automatic void queue_expected(input text_result_t r);
        expected_q = {expected_q, r};
    endfunction

    function automatic void emit_data(input logic [7:0] b);
        text_result_t r;
        r.data = b;
        r.kind = KIND_DATA;
        r.last = 1'b0;
        queue_expected(r);
    endfunction

    // Encodes one code point as UTF-8 and queues its bytes in order.
    function automatic void emit_code_point(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            emit_data(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            emit_data({3'b110, cp[10:6]});
            emit_data({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            emit_data({4'b1110, cp[15:12]});
            emit_data({2'b10, cp[11:6]});
            emit_data({2'b10, cp[5:0]});
        end
        else
        begin
            emit_data({5'b11110, cp[20:18]});
            emit_data({2'b10, cp[17:12]});
            emit_data({2'b10, cp[11:6]});
            emit_data({2'b10, cp[5:0]});
        end
    endfunction

    // Advances the decoder by one input word and queues the words it must send.
    function automatic void decode_word(input logic [7:0] b, input logic eot);
        int           digit;
        logic [15:0]  acc_next;
        bit           status_due;
        logic [1:0]   status_kind;
        text_result_t r;

        digit       = hex_nibble(b);
        acc_next    = {hex_acc[11:0], digit[3:0]};
        status_due  = 1'b0;
        status_kind = KIND_ERROR;

        case (mode)
            ST_IDLE:
            begin
                if (b == CH_QUOTE)
                    mode = ST_TEXT;
                else
                    status_due = 1'b1;
            end
            ST_TEXT:
            begin
                if (b == CH_QUOTE)
                begin
                    status_due  = 1'b1;
                    status_kind = KIND_CLOSE;
                end
                else if (b == CH_BSLASH)
                    mode = ST_ESC;
                else if (b < CTRL_LIMIT)
                    status_due = 1'b1;
                else
                    emit_data(b);
            end
            ST_ESC:
            begin
                mode = ST_TEXT;
                case (b)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: emit_data(b);
                    CH_B: emit_data(8'h08);
                    CH_F: emit_data(8'h0C);
                    CH_N: emit_data(8'h0A);
                    CH_R: emit_data(8'h0D);
                    CH_T: emit_data(8'h09);
                    CH_U:
                    begin
                        hex_acc = 16'h0000;
                        mode    = ST_HEX1;
                    end
                    default: status_due = 1'b1;
                endcase
            end
            ST_HEX1, ST_HEX2, ST_HEX3, ST_HEX4:
            begin
                if (digit < 0)
                    status_due = 1'b1;
                else
                begin
                    hex_acc = acc_next;
                    if (mode != ST_HEX4)
                        mode = decode_state_t'(mode + 4'd1);
                    else if (hex_acc[15:10] == SURR_HIGH_TAG)
                    begin
                        hi_half = hex_acc[9:0];
                        mode    = ST_PAIR_BS;
                    end
                    else if (hex_acc[15:10] == SURR_LOW_TAG)
                        status_due = 1'b1;
                    else
                    begin
                        emit_code_point({5'd0, hex_acc});
                        mode = ST_TEXT;
                    end
                end
            end
            ST_PAIR_BS:
            begin
                if (b == CH_BSLASH)
                    mode = ST_PAIR_U;
                else
                    status_due = 1'b1;
            end
            ST_PAIR_U:
            begin
                if (b == CH_U)
                begin
                    hex_acc = 16'h0000;
                    mode    = ST_LO1;
                end
                else
                    status_due = 1'b1;
            end
            default:
            begin
                // Low half of a surrogate pair.
                if (digit < 0)
                    status_due = 1'b1;
                else
                begin
                    hex_acc = acc_next;
                    if (mode != ST_LO4)
                        mode = decode_state_t'(mode + 4'd1);
                    else if (hex_acc[15:10] == SURR_LOW_TAG)
                    begin
                        emit_code_point(SUPPLEMENTARY_BASE + {1'b0, hi_half, hex_acc[9:0]});
                        mode = ST_TEXT;
                    end
                    else
                        status_due = 1'b1;
                end
            end
        endcase

        // Text that ends without a close or an error is itself an error.
        if (!status_due && eot)
            status_due = 1'b1;

        if (status_due)
        begin
            r.data = 8'h00;
            r.kind = status_kind;
            r.last = 1'b1;
            queue_expected(r);
            mode    = ST_IDLE;
            hex_acc = 16'h0000;
            hi_half = 10'd0;
        end
    endfunction

    // Predict on every accepted input word, compare on every accepted output word.
    always @(posedge clk or negedge rst_n)
    begin
        text_result_t want;
        if (!rst_n)
        begin
            mode            = ST_IDLE;
            hex_acc         = 16'h0000;
            hi_half         = 10'd0;
            fail_count      = 0;
            pending_results = 0;
            expected_q.delete();
        end
        else
        begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                decode_word(in_ch.in_byte, in_ch.end_of_text);

            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word: expected none, %s %02h kind %0d last %0b",
                             $time, "actual byte", out_ch.out_byte, out_ch.kind,
                             out_ch.last);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_ch.out_byte !== want.data)
                    begin
                        fail_count++;
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.data, out_ch.out_byte);
                    end
                    if (out_ch.kind !== want.kind)
                    begin
                        fail_count++;
                        $display("%0t: kind mismatch: expected %0d, actual %0d",
                                 $time, want.kind, out_ch.kind);
                    end
                    if (out_ch.last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, out_ch.last);
                    end
                end
            end
            pending_results = expected_q.size();
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Top of the JSON string unescaper testbench: clock, reset, text stimulus and output stalls.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, json_string_unescape_utf8 and jsu_decode_check.
module tb;
    import jsu_pkg::*;

    localparam int ITEM_TARGET  = 270;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_LIMIT  = 20000;
    localparam logic [15:0] BMP_EDGES [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                              16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

    typedef logic [7:0] text_t[$];

    typedef enum int {
        FLAW_CONTROL,
        FLAW_BAD_ESCAPE,
        FLAW_BAD_HEX,
        FLAW_LONE_LOW,
        FLAW_UNPAIRED_HIGH,
        FLAW_NO_QUOTE,
        FLAW_TRUNCATE
    } flaw_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_results;
    int   cycle_count;
    int   sent_items;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_utf8 uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    jsu_decode_check decode_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short idle gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit is_hex(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'("0") + 8'(n);
        return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (is_hex(b));
        return b;
    endfunction

    // Printable byte that needs no escape.
    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] short_escape_char();
        case ($urandom_range(0, 7))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic logic [7:0] bad_escape_char();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
        return b;
    endfunction

    // Code point of the basic plane outside the surrogate range, edges included.
    function automatic logic [15:0] pick_code_point();
        logic [15:0] v;
        if ($urandom_range(0, 4) == 0)
            return BMP_EDGES[$urandom_range(0, 7)];
        case ($urandom_range(0, 2))
            0: v = 16'($urandom_range(16'h0000, 16'h007F));
            1: v = 16'($urandom_range(16'h0080, 16'h07FF));
            default:
            begin
                do v = 16'($urandom_range(16'h0800, 16'hFFFF));
                while (v >= 16'hD800 && v <= 16'hDFFF);
            end
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_high();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 16'hD800 : 16'hDBFF;
        return 16'($urandom_range(16'hD800, 16'hDBFF));
    endfunction

    function automatic logic [15:0] pick_low();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 16'hDC00 : 16'hDFFF;
        return 16'($urandom_range(16'hDC00, 16'hDFFF));
    endfunction

    // Appends one byte at the end of a text.
    task automatic add_char(ref text_t text, input logic [7:0] b);
        text = {text, b};
    endtask

    task automatic append_u(ref text_t text, input logic [15:0] v);
        add_char(text, CH_BSLASH);
        add_char(text, CH_U);
        for (int i = 3; i >= 0; i--)
            add_char(text, hex_char(v[i*4 +: 4]));
    endtask

    // One well-formed piece of string content.
    task automatic append_piece(ref text_t text);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            add_char(text, plain_char());
        else if (r < 65)
        begin
            add_char(text, CH_BSLASH);
            add_char(text, short_escape_char());
        end
        else if (r < 85)
            append_u(text, pick_code_point());
        else
        begin
            append_u(text, pick_high());
            append_u(text, pick_low());
        end
    endtask

    // One defect; a truncation also ends the text with end_of_text.
    task automatic append_flaw(ref text_t text, output bit truncated);
        flaw_t      flaw;
        logic [7:0] b;
        truncated = 1'b0;
        flaw = flaw_t'($urandom_range(0, 6));
        case (flaw)
            FLAW_CONTROL:
                add_char(text, 8'($urandom_range(0, 8'h1F)));
            FLAW_BAD_ESCAPE:
            begin
                add_char(text, CH_BSLASH);
                add_char(text, bad_escape_char());
            end
            FLAW_BAD_HEX:
            begin
                add_char(text, CH_BSLASH);
                add_char(text, CH_U);
                repeat ($urandom_range(0, 3))
                    add_char(text, hex_char(4'($urandom_range(0, 15))));
                add_char(text, non_hex_char());
            end
            FLAW_LONE_LOW:
                append_u(text, pick_low());
            FLAW_UNPAIRED_HIGH:
            begin
                append_u(text, pick_high());
                case ($urandom_range(0, 2))
                    0: add_char(text, plain_char());
                    1:
                    begin
                        add_char(text, CH_BSLASH);
                        do b = 8'($urandom_range(0, 255)); while (b == CH_U);
                        add_char(text, b);
                    end
                    default: append_u(text, pick_code_point());
                endcase
            end
            FLAW_NO_QUOTE:
            begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
                text[0] = b;
            end
            default:
            begin
                // Text ends early, possibly inside an escape.
                truncated = 1'b1;
                case ($urandom_range(0, 3))
                    0: ;
                    1: add_char(text, CH_BSLASH);
                    2:
                    begin
                        add_char(text, CH_BSLASH);
                        add_char(text, CH_U);
                        repeat ($urandom_range(0, 3))
                            add_char(text, hex_char(4'($urandom_range(0, 15))));
                    end
                    default: append_u(text, pick_high());
                endcase
            end
        endcase
    endtask

    // Builds one string literal, with or without a defect.
    task automatic compose_text(ref text_t text, input bit flawed, output bit truncated);
        int pieces;
        int flaw_at;
        truncated = 1'b0;
        add_char(text, CH_QUOTE);
        pieces  = $urandom_range(0, 6);
        flaw_at = flawed ? $urandom_range(0, pieces) : -1;
        for (int i = 0; i <= pieces; i++)
        begin
            if (i == flaw_at)
            begin
                append_flaw(text, truncated);
                if (truncated)
                    break;
            end
            if (i < pieces)
                append_piece(text);
        end
        if (!truncated)
            add_char(text, CH_QUOTE);
    endtask

    // Offers one word and holds it until the block takes it.
    task automatic send_word(input logic [7:0] b, input logic eot, input bit gapless);
        int gap;
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= b;
        in_ch.end_of_text <= eot;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        sent_items++;
        gap = gapless ? 0 : idle_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input text_t text, input bit eot, input bit gapless);
        for (int i = 0; i < text.size(); i++)
            send_word(text[i], eot && (i == text.size() - 1), gapless);
    endtask

    // Holds the input off until every expected word has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_results != 0);
        @(posedge clk);
    endtask

    // Output stalls: short runs and gaps, with some long stall-free stretches.
    initial
    begin
        int run;
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = idle_gap();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        text_t text;
        bit    eot;
        bit    truncated;
        bit    gapless;
        int    choice;
        int    drain_wait;

        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = 8'h00;
        in_ch.end_of_text = 1'b0;
        sent_items        = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: missing opening quote.
        text = '{"x"};
        send_text(text, 1'b0, 1'b0);
        // Plain byte extremes, a short escape, then a control byte.
        text = '{CH_QUOTE, 8'h20, 8'hFF, CH_BSLASH, CH_N, 8'h1F};
        send_text(text, 1'b0, 1'b0);
        // Surrogate pair to four UTF-8 bytes, closed on the last word of the text.
        text = '{CH_QUOTE, CH_BSLASH, CH_U, "d", "8", "3", "D",
                 CH_BSLASH, CH_U, "D", "E", "0", "0", CH_QUOTE};
        send_text(text, 1'b1, 1'b1);
        // Lone low surrogate.
        text = '{CH_QUOTE, CH_BSLASH, CH_U, "d", "c", "0", "0"};
        send_text(text, 1'b0, 1'b0);
        // Text ends after decoded data; the data stays.
        text = '{CH_QUOTE, "a"};
        send_text(text, 1'b1, 1'b0);
        wait_drained();

        // Random: mostly well-formed strings, some with defects, some noise.
        while (sent_items < ITEM_TARGET)
        begin
            choice  = $urandom_range(0, 99);
            gapless = ($urandom_range(0, 3) == 0);
            if (choice < 5)
                wait_drained();
            text.delete();
            if (choice < 10)
            begin
                add_char(text, 8'($urandom_range(0, 255)));
                eot = 1'($urandom_range(0, 1));
            end
            else
            begin
                compose_text(text, choice < 35, truncated);
                eot = truncated || ($urandom_range(0, 3) == 0);
            end
            send_text(text, eot, gapless);
        end
        in_ch.valid <= 1'b0;

        // Let the last words out, then give stray ones a chance to show.
        drain_wait = 0;
        while (pending_results != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain_wait++;
        end
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (pending_results != 0)
            $display("%0t: %0d expected words never came out", $time, pending_results);
        if (fail_count == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
